// ===== hdl/lfme_pkg.sv =====
// ----------------------------------------------------------------------------
// Line FIR package
// Types and constants shared by the line FIR filter with mirrored edges.
// ----------------------------------------------------------------------------
package lfme_pkg;

    localparam int NUM_COEF    = 7;
    localparam int CENTER_COEF = 3;
    localparam int PIX_W       = 8;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = COEF_W + PIX_W + 1;
    localparam int SUM_W       = PROD_W + 3;
    localparam int FILT_W      = 27;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t COEF_RESET [NUM_COEF] = '{
        16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0
    };

    typedef enum logic [2:0] {
        REG_COEF_0 = 3'd0,
        REG_COEF_1 = 3'd1,
        REG_COEF_2 = 3'd2,
        REG_COEF_3 = 3'd3,
        REG_COEF_4 = 3'd4,
        REG_COEF_5 = 3'd5,
        REG_COEF_6 = 3'd6,
        REG_NONE   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] sample;
        logic             line_end;
    } pixel_beat_t;

    typedef struct packed {
        logic signed [FILT_W-1:0] filtered;
        logic                     burst_last;
        logic                     short_line;
    } result_beat_t;

    typedef struct packed {
        logic last;
        logic short_line;
    } job_flags_t;

    localparam int FLAGS_W = $bits(job_flags_t);

    typedef struct packed {
        logic push;
        logic flushing;
    } front_stat_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_stat_t;

endpackage

// ===== hdl/lfme_regs.sv =====
// ----------------------------------------------------------------------------
// Line FIR coefficient registers
// APB-style register file holding the seven signed tap weights.
// ----------------------------------------------------------------------------
module lfme_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfme_pkg::PADDR_W-1:0]  paddr,
    input  logic [lfme_pkg::PDATA_W-1:0]  pwdata,
    output logic [lfme_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output lfme_pkg::coef_t               coef [lfme_pkg::NUM_COEF]
);
    import lfme_pkg::*;

    coef_t    coef_reg [NUM_COEF];
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COEF; k++)
            begin
                coef_reg[k] <= COEF_RESET[k];
            end
        end
        else if (wr_en && idx != REG_NONE)
        begin
            coef_reg[idx] <= pwdata[COEF_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx != REG_NONE)
        begin
            prdata = PDATA_W'(coef_reg[idx]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_COEF; k++)
        begin
            coef[k] = coef_reg[k];
        end
    end

endmodule

// ===== hdl/lfme_front.sv =====
// ----------------------------------------------------------------------------
// Line FIR front end
// Accepts pixels, keeps the mirrored window and line position, and queues
// one window snapshot per result, including the end-of-line flush.
// ----------------------------------------------------------------------------
module lfme_front #(
    parameter int HALF = 3,
    parameter int WIN  = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    output logic                               pix_ready,
    input  lfme_pkg::pixel_beat_t              pix,
    input  lfme_pkg::queue_stat_t              q_stat,
    output lfme_pkg::front_stat_t              f_stat,
    output logic [WIN*lfme_pkg::PIX_W-1:0]     q_win,
    output lfme_pkg::job_flags_t               q_flags
);
    import lfme_pkg::*;

    localparam int POS_W = $clog2(HALF + 2);
    localparam int CNT_W = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int IDX_W = $clog2(WIN);

    typedef enum logic [1:0] {
        ST_STREAM = 2'b01,
        ST_FLUSH  = 2'b10
    } front_state_t;

    front_state_t               state_reg, state_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [WIN-1:0][PIX_W-1:0]  win_reg, win_next;
    logic [WIN-1:0][PIX_W-1:0]  shifted;
    logic [IDX_W-1:0]           sel;
    logic                       accept;
    logic                       push;
    job_flags_t                 flags;

    assign pix_ready = (state_reg == ST_STREAM) && !q_stat.full;
    assign accept    = pix_valid && pix_ready;
    assign sel       = IDX_W'(WIN - 1) - IDX_W'({cnt_reg, 1'b0});

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        win_next   = win_reg;
        push       = 1'b0;
        flags      = '0;
        shifted    = win_reg;
        case (state_reg)
            ST_STREAM:
            begin
                shifted = {pix.sample, win_reg[WIN-1:1]};
                if (accept)
                begin
                    win_next = shifted;
                    if (pos_reg < POS_W'(HALF))
                    begin
                        if (pix.line_end)
                        begin
                            push             = 1'b1;
                            flags.last       = 1'b1;
                            flags.short_line = 1'b1;
                            pos_next         = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (pos_reg == POS_W'(HALF))
                        begin
                            for (int k = 1; k <= HALF; k++)
                            begin
                                win_next[HALF-k] = shifted[HALF+k];
                            end
                        end
                        pos_next = POS_W'(HALF + 1);
                        push     = 1'b1;
                        if (pix.line_end)
                        begin
                            state_next = ST_FLUSH;
                            cnt_next   = '0;
                            pos_next   = '0;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                shifted = {win_reg[sel], win_reg[WIN-1:1]};
                if (!q_stat.full)
                begin
                    win_next = shifted;
                    push     = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(HALF - 1))
                    begin
                        flags.last = 1'b1;
                        state_next = ST_STREAM;
                    end
                end
            end
            default:
            begin
                state_next = ST_STREAM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_STREAM;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            win_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            win_reg   <= win_next;
        end
    end

    assign q_win           = win_next;
    assign q_flags         = flags;
    assign f_stat.push     = push;
    assign f_stat.flushing = (state_reg == ST_FLUSH);

endmodule

// ===== hdl/lfme_queue.sv =====
// ----------------------------------------------------------------------------
// Line FIR job queue
// Short first-in first-out queue of window snapshots between the front
// end and the arithmetic back end.
// ----------------------------------------------------------------------------
module lfme_queue #(
    parameter int DATA_W = 58
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_W-1:0]     push_data,
    input  logic                  pop,
    output logic [DATA_W-1:0]     pop_data,
    output lfme_pkg::queue_stat_t q_stat
);
    import lfme_pkg::*;

    logic [DATA_W-1:0] mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == (QPTR_W + 1)'(QDEPTH));

endmodule

// ===== hdl/lfme_back.sv =====
// ----------------------------------------------------------------------------
// Line FIR back end
// Two-stage multiply and sum over one window snapshot per beat, ending in
// the result output register.
// ----------------------------------------------------------------------------
module lfme_back #(
    parameter int HALF = 3,
    parameter int WIN  = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lfme_pkg::coef_t                   coef [lfme_pkg::NUM_COEF],
    input  lfme_pkg::queue_stat_t             q_stat,
    input  logic [WIN*lfme_pkg::PIX_W-1:0]    q_win,
    input  lfme_pkg::job_flags_t              q_flags,
    output logic                              pop,
    output logic                              res_valid,
    input  logic                              res_ready,
    output lfme_pkg::result_beat_t            res
);
    import lfme_pkg::*;

    logic [WIN-1:0][PIX_W-1:0]  win;
    logic signed [PROD_W-1:0]   prod_reg [WIN];
    job_flags_t                 s1_flags_reg;
    logic                       s1_valid_reg;
    logic                       res_valid_reg;
    result_beat_t               res_reg;
    logic signed [SUM_W-1:0]    acc;
    logic                       s1_en, s2_en;

    assign win   = q_win;
    assign s2_en = !res_valid_reg || res_ready;
    assign s1_en = !s1_valid_reg || s2_en;
    assign pop   = q_stat.valid && s1_en;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                prod_reg[k] <= $signed(coef[CENTER_COEF - HALF + k])
                             * $signed({1'b0, win[k]});
            end
            s1_flags_reg <= q_flags;
        end
    end

    always_comb
    begin
        acc = '0;
        for (int k = 0; k < WIN; k++)
        begin
            acc = acc + SUM_W'(prod_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            res_reg.filtered   <= s1_flags_reg.short_line ? '0 : acc[FILT_W-1:0];
            res_reg.burst_last <= s1_flags_reg.last;
            res_reg.short_line <= s1_flags_reg.short_line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= q_stat.valid;
            end
            if (s2_en)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hdl/line_fir_mirror_edges_unit.sv =====
// ----------------------------------------------------------------------------
// Line FIR filter with mirrored edges
// Odd-length FIR filter along one streamed image line with mirrored borders.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock and returns one result beat per
// clock once the first HALF pixels of a line are in, while the queue is not
// full and the output is not held off. The pixel marked as the line end
// blocks the input while the front end pushes the HALF mirrored flush results
// into a four-entry queue; that flush loop and a full queue set the gaps in
// the input rate. Each result passes the queue entry, the multiply stage and
// the sum stage that ends in the output register. A short line gives a single
// beat with short_line set. Coefficients are to be written over the APB port
// only while the block is idle; the block itself does not enforce this.
module line_fir_mirror_edges_unit #(
    parameter int TAPS = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfme_pkg::PADDR_W-1:0]  paddr,
    input  logic [lfme_pkg::PDATA_W-1:0]  pwdata,
    output logic [lfme_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  lfme_pkg::pixel_beat_t         pix,
    output logic                          res_valid,
    input  logic                          res_ready,
    output lfme_pkg::result_beat_t        res
);
    import lfme_pkg::*;

    localparam int HALF   = TAPS / 2;
    localparam int WIN    = 2 * HALF + 1;
    localparam int DATA_W = FLAGS_W + WIN * PIX_W;

    coef_t                  coef [NUM_COEF];
    front_stat_t            f_stat;
    queue_stat_t            q_stat;
    logic [WIN*PIX_W-1:0]   f_win;
    job_flags_t             f_flags;
    logic [DATA_W-1:0]      q_out;
    logic                   pop;

    lfme_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    lfme_front #(
        .HALF (HALF),
        .WIN  (WIN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .q_stat    (q_stat),
        .f_stat    (f_stat),
        .q_win     (f_win),
        .q_flags   (f_flags)
    );

    lfme_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_stat.push),
        .push_data ({f_flags, f_win}),
        .pop       (pop),
        .pop_data  (q_out),
        .q_stat    (q_stat)
    );

    lfme_back #(
        .HALF (HALF),
        .WIN  (WIN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .q_stat    (q_stat),
        .q_win     (q_out[WIN*PIX_W-1:0]),
        .q_flags   (job_flags_t'(q_out[DATA_W-1 -: FLAGS_W])),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        f_stat.push |-> !q_stat.full)
    else $error("queue push while full");

    // A flush only starts right after a pixel marked as the line end.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(f_stat.flushing) |-> $past(pix_valid && pix_ready && pix.line_end))
    else $error("flush started without a line end");

    // A short-line beat is always the last of its line and carries zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.short_line) |-> (res.burst_last && res.filtered == '0))
    else $error("malformed short-line beat");

endmodule

// ===== dv/line_fir_mirror_edges_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line FIR checker
// Watches the pixel, result and APB channels of the line FIR filter. It keeps
// its own copy of the tap weights, the pixel window and the line position,
// predicts the result beats of every pixel beat and compares each result
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module line_fir_mirror_edges_checker #(
    parameter int TAPS = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [lfme_pkg::PADDR_W-1:0]  paddr,
    input  logic [lfme_pkg::PDATA_W-1:0]  pwdata,
    input  logic                          pix_valid,
    input  logic                          pix_ready,
    input  lfme_pkg::pixel_beat_t         pix,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  lfme_pkg::result_beat_t        res,
    output int                            fail_count,
    output int                            results_left,
    output int                            results_seen
);
    import lfme_pkg::*;

    localparam int HALF = TAPS / 2;
    localparam int WIN  = 2 * HALF + 1;

    coef_t            tap_weights [NUM_COEF];
    logic [PIX_W-1:0] window [WIN];
    int               line_pos;
    int               errors;
    int               beats_checked;
    result_beat_t     expected_results [$];

    function automatic logic signed [FILT_W-1:0] window_sum();
        longint acc;
        acc = 0;
        for (int k = 0; k < WIN; k++)
            acc += longint'(tap_weights[CENTER_COEF - HALF + k]) * longint'(window[k]);
        return acc[FILT_W-1:0];
    endfunction

    function automatic void shift_pixel(logic [PIX_W-1:0] value);
        for (int k = 0; k < WIN - 1; k++)
            window[k] = window[k + 1];
        window[WIN - 1] = value;
    endfunction

    function automatic void predict_pixel(pixel_beat_t beat);
        shift_pixel(beat.sample);
        if (line_pos < HALF)
        begin
            if (beat.line_end)
            begin
                expected_results.push_back(result_beat_t'{filtered: '0, burst_last: 1'b1,
                                                          short_line: 1'b1});
                line_pos = 0;
            end
            else
                line_pos++;
        end
        else
        begin
            if (line_pos == HALF)
            begin
                for (int k = 1; k <= HALF; k++)
                    window[HALF - k] = window[HALF + k];
                line_pos = HALF + 1;
            end
            expected_results.push_back(result_beat_t'{filtered: window_sum(), burst_last: 1'b0,
                                                      short_line: 1'b0});
            if (beat.line_end)
            begin
                for (int j = 0; j < HALF; j++)
                begin
                    shift_pixel(window[WIN - 1 - 2 * j]);
                    expected_results.push_back(result_beat_t'{filtered: window_sum(),
                                                              burst_last: (j == HALF - 1),
                                                              short_line: 1'b0});
                end
                line_pos = 0;
            end
        end
    endfunction

    function automatic void check_result(result_beat_t got);
        result_beat_t want;
        beats_checked++;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result beat: filtered %0d burst_last %0b short_line %0b",
                   got.filtered, got.burst_last, got.short_line);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.filtered !== want.filtered)
        begin
            $error("filtered: expected %0d, actual %0d", want.filtered, got.filtered);
            errors++;
        end
        if (got.burst_last !== want.burst_last)
        begin
            $error("burst_last: expected %0b, actual %0b", want.burst_last, got.burst_last);
            errors++;
        end
        if (got.short_line !== want.short_line)
        begin
            $error("short_line: expected %0b, actual %0b", want.short_line, got.short_line);
            errors++;
        end
    endfunction

    function automatic void write_tap(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        reg_idx_t idx;
        idx = reg_idx_t'(addr[PADDR_W-1:2]);
        if (idx != REG_NONE)
            tap_weights[idx] = coef_t'(data[COEF_W-1:0]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_weights = COEF_RESET;
            foreach (window[k])
                window[k] = '0;
            line_pos = 0;
            errors = 0;
            beats_checked = 0;
            expected_results.delete();
        end
        else
        begin
            if (res_valid && res_ready)
                check_result(res);
            if (pix_valid && pix_ready)
                predict_pixel(pix);
            if (psel && penable && pwrite && pready)
                write_tap(paddr, pwdata);
        end
        fail_count   <= errors;
        results_left <= expected_results.size();
        results_seen <= beats_checked;
    end

endmodule

// ===== dv/line_fir_mirror_edges_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line FIR filter testbench
// Streams directed and random image lines into the line FIR filter under
// several tap settings and idle profiles, holds the output off once for a
// long stretch, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module line_fir_mirror_edges_unit_tb;

    import lfme_pkg::*;

    localparam int     TAPS            = 7;
    localparam int     HALF            = TAPS / 2;
    localparam int     SETTLE_CYCLES   = 16;
    localparam int     HOLD_CYCLES     = 90;
    localparam int     ITEMS_PER_PHASE = 70;
    localparam longint CYCLE_LIMIT     = 200000;

    typedef enum int {
        TAP_SET_MAX,
        TAP_SET_MIN,
        TAP_SET_RANDOM,
        TAP_SET_MIXED
    } tap_set_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               pix_valid = 1'b0;
    logic               pix_ready;
    pixel_beat_t        pix       = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    result_beat_t       res;

    int     fail_count;
    int     results_left;
    int     results_seen;
    int     pix_idle_pct = 0;
    int     res_idle_pct = 0;
    int     holds_asked  = 0;
    int     holds_served;
    int     hold_left;
    int     pixels_sent  = 0;
    int     lines_sent   = 0;
    int     short_lines  = 0;
    int     line_len     = 0;
    int     tap_settings = 0;
    longint cycle_count  = 0;

    line_fir_mirror_edges_unit #(
        .TAPS(TAPS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .pix_valid(pix_valid),
        .pix_ready(pix_ready),
        .pix      (pix),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    line_fir_mirror_edges_checker #(
        .TAPS(TAPS)
    ) fir_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix         (pix),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .fail_count  (fail_count),
        .results_left(results_left),
        .results_seen(results_seen)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            hold_left = 0;
            holds_served = 0;
        end
        else
        begin
            if (holds_served != holds_asked)
            begin
                holds_served = holds_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= res_idle_pct);
        end
    end

    task automatic send_pixel(logic [PIX_W-1:0] value, logic last);
        while ($urandom_range(99) < pix_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix <= pixel_beat_t'{sample: value, line_end: last};
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        pixels_sent++;
        line_len++;
        if (last)
        begin
            lines_sent++;
            if (line_len <= HALF)
                short_lines++;
            line_len = 0;
        end
    endtask

    task automatic send_fixed_line(int len, logic [PIX_W-1:0] even_px, logic [PIX_W-1:0] odd_px);
        for (int i = 0; i < len; i++)
            send_pixel((i % 2 == 0) ? even_px : odd_px, i == len - 1);
    endtask

    task automatic send_random_line();
        int               len;
        int               pick;
        logic [PIX_W-1:0] px;
        pick = $urandom_range(9);
        if (pick == 0)
            len = $urandom_range(HALF, 1);
        else if (pick == 1)
            len = $urandom_range(40, 25);
        else
            len = $urandom_range(12, HALF + 1);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(7))
                0:       px = '0;
                1:       px = '1;
                default: px = PIX_W'($urandom);
            endcase
            send_pixel(px, i == len - 1);
        end
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (results_left != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    function automatic coef_t pick_tap(tap_set_t kind);
        case (kind)
            TAP_SET_MAX:    return coef_t'(32767);
            TAP_SET_MIN:    return coef_t'(-32768);
            TAP_SET_RANDOM: return coef_t'($urandom);
            default:
            begin
                case ($urandom_range(3))
                    0:       return coef_t'(32767);
                    1:       return coef_t'(-32768);
                    2:       return coef_t'(0);
                    default: return coef_t'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic load_taps(tap_set_t kind);
        coef_t value;
        for (int i = 0; i < NUM_COEF; i++)
        begin
            value = pick_tap(kind);
            write_reg(reg_idx_t'(i), {{(PDATA_W - COEF_W){value[COEF_W-1]}}, value});
        end
        if (kind == TAP_SET_MAX)
            write_reg(REG_NONE, PDATA_W'($urandom));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tap_settings++;
    endtask

    initial
    begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pix_idle_pct = 19;
        res_idle_pct = 48;
        send_fixed_line(1, 8'hFF, 8'h00);
        send_fixed_line(HALF, 8'h00, 8'hFF);
        send_fixed_line(HALF + 1, 8'hFF, 8'h00);
        send_fixed_line(2, 8'h5A, 8'hA5);
        drain();
        load_taps(TAP_SET_MAX);
        send_fixed_line(HALF + 3, 8'hFF, 8'hFF);
        drain();
        load_taps(TAP_SET_MIN);
        send_fixed_line(HALF + 3, 8'hFF, 8'hFF);
        send_fixed_line(HALF + 2, 8'h00, 8'hFF);

        for (int mode = 0; mode < 3; mode++)
        begin
            pix_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 48 : 0;
            res_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 19 : 0;
            for (int sub = 0; sub < 2; sub++)
            begin
                drain();
                load_taps((sub == 0) ? TAP_SET_RANDOM : TAP_SET_MIXED);
                if (mode == 0 && sub == 0)
                    holds_asked++;
                target = pixels_sent + ITEMS_PER_PHASE;
                while (pixels_sent < target)
                    send_random_line();
            end
        end
        drain();

        $display("Run covered %0d pixel beats in %0d lines (%0d short) over %0d tap settings,",
                 pixels_sent, lines_sent, short_lines, tap_settings);
        $display("three idle profiles and one long output hold; %0d result beats checked.",
                 results_seen);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
